// File: rtl/core/cbpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpm_pkg
// Shared types and codes of the buffer pool frame manager.
// ----------------------------------------------------------------------------
package cbpm_pkg;

  localparam int KindW   = 3;
  localparam int FileW   = 8;
  localparam int PageW   = 32;
  localparam int StatusW = 3;
  localparam int FrameW  = 4;
  localparam int PinW    = 8;

  typedef enum logic [KindW-1:0] {
    KIND_READ    = 3'd0,
    KIND_UNPIN   = 3'd1,
    KIND_ALLOC   = 3'd2,
    KIND_DISPOSE = 3'd3,
    KIND_FLUSH   = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_EXCEEDED   = 3'd1,
    ST_NOT_PINNED = 3'd2,
    ST_PINNED     = 3'd3,
    ST_BAD_BUFFER = 3'd4,
    ST_NOT_FOUND  = 3'd5
  } status_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [FileW-1:0] file_id;
    logic [PageW-1:0] page_no;
    logic             mark_dirty;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [FrameW-1:0]  frame;
    logic               hit;
    logic               writeback;
    logic [FileW-1:0]   wb_file_id;
    logic [PageW-1:0]   wb_page_no;
    logic               last;
  } rsp_t;

endpackage
`default_nettype wire

// File: rtl/core/cbpm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbpm_req_if / cbpm_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface cbpm_req_if import cbpm_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cbpm_rsp_if import cbpm_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/clock_buffer_pool_manager_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A lookup visits the frames one at a time, up to NUM_FRAMES; a read or allocate
// miss then sweeps the clock hand, up to 2*NUM_FRAMES visits. A flush scans the frames,
// stops at a pinned match, and emits each dirty match as a write-back held until taken.
// One request is handled at a time; ready returns the cycle after the final result
// is taken. Reset clears valid/pin/ref/dirty of every frame and sets the hand to the
// last frame; owner fields are not reset.
// ----------------------------------------------------------------------------
// clock_buffer_pool_manager_core
// Clock-replacement frame manager with a sequential descriptor walker.
// ----------------------------------------------------------------------------
module clock_buffer_pool_manager_core import cbpm_pkg::*; #(
  parameter int NUM_FRAMES = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  cbpm_req_if.sink     req_i,
  cbpm_rsp_if.source   rsp_o
);

  localparam int IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CntW = $clog2(2 * NUM_FRAMES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FRAMES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_SWEEP  = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  logic [2:0]      state_q;
  logic [NUM_FRAMES-1:0] valid_q, ref_q, dirty_q;
  logic [PinW-1:0] pin_q [NUM_FRAMES];
  logic [FileW-1:0] ofile_q [NUM_FRAMES];
  logic [PageW-1:0] opage_q [NUM_FRAMES];
  logic [IdxW-1:0] hand_q;
  logic [IdxW-1:0] idx_q;
  logic [CntW-1:0] cnt_q;
  req_t            req_q;
  rsp_t            rsp_q;
  logic            rsp_vld_q;

  // walker frame selection (shared unit)
  logic [IdxW-1:0] nxt_hand;
  logic [IdxW-1:0] cur;
  logic            match;
  logic            idx_last;

  assign nxt_hand = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
  assign cur      = (state_q == S_SWEEP) ? nxt_hand : idx_q;
  assign match    = valid_q[cur] && ofile_q[cur] == req_q.file_id &&
                    (state_q == S_FLUSH || opage_q[cur] == req_q.page_no);
  assign idx_last = (idx_q == LastIdx);

  assign req_i.ready = (state_q == S_IDLE) && !rsp_vld_q;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  function automatic rsp_t mk(logic [StatusW-1:0] st, logic [IdxW-1:0] fr,
                              logic h, logic lst);
    rsp_t r;
    r = '0;
    r.status = st;
    r.frame  = FrameW'(fr);
    r.hit    = h;
    r.last   = lst;
    return r;
  endfunction

  // ok result that carries a write-back of the given page
  function automatic rsp_t mk_wb(logic [IdxW-1:0] fr, logic lst,
                                 logic [FileW-1:0] wf, logic [PageW-1:0] wp);
    rsp_t r;
    r = mk(ST_OK, fr, 1'b0, lst);
    r.writeback  = 1'b1;
    r.wb_file_id = wf;
    r.wb_page_no = wp;
    return r;
  endfunction

  // sequencer and descriptor updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      ref_q       <= '0;
      dirty_q     <= '0;
      hand_q      <= LastIdx;
      idx_q       <= '0;
      cnt_q       <= '0;
      rsp_vld_q   <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) pin_q[i] <= '0;
    end else begin
      if (rsp_vld_q && rsp_o.ready && state_q != S_OUT) rsp_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid && req_i.ready) begin
            req_q <= req_i.data;
            idx_q <= '0;
            cnt_q <= '0;
            if (req_i.data.kind == KIND_FLUSH) state_q <= S_FLUSH;
            else if (req_i.data.kind <= KIND_DISPOSE) state_q <= S_LOOK;
          end
        end
        // associative lookup, one frame per cycle
        S_LOOK: begin
          if (match) begin
            state_q   <= S_IDLE;
            rsp_vld_q <= 1'b1;
            case (req_q.kind)
              KIND_UNPIN: begin
                if (pin_q[cur] == '0) rsp_q <= mk(ST_NOT_PINNED, cur, 1'b1, 1'b1);
                else begin
                  pin_q[cur] <= pin_q[cur] - 1'b1;
                  if (req_q.mark_dirty) dirty_q[cur] <= 1'b1;
                  rsp_q <= mk(ST_OK, cur, 1'b1, 1'b1);
                end
              end
              KIND_DISPOSE: begin
                valid_q[cur] <= 1'b0;
                ref_q[cur]   <= 1'b0;
                dirty_q[cur] <= 1'b0;
                pin_q[cur]   <= '0;
                rsp_q <= mk(ST_OK, cur, 1'b1, 1'b1);
              end
              default: begin
                ref_q[cur] <= 1'b1;
                if (pin_q[cur] != '1) pin_q[cur] <= pin_q[cur] + 1'b1;
                rsp_q <= mk(ST_OK, cur, 1'b1, 1'b1);
              end
            endcase
          end else if (idx_last) begin
            if (req_q.kind == KIND_UNPIN || req_q.kind == KIND_DISPOSE) begin
              state_q   <= S_IDLE;
              rsp_vld_q <= 1'b1;
              rsp_q     <= mk(ST_NOT_FOUND, '0, 1'b0, 1'b1);
            end else state_q <= S_SWEEP;
          end else idx_q <= idx_q + 1'b1;
        end
        // clock sweep, one hand step per cycle
        S_SWEEP: begin
          hand_q <= nxt_hand;
          cnt_q  <= cnt_q + 1'b1;
          if (!valid_q[cur] || (!ref_q[cur] && pin_q[cur] == '0)) begin
            if (valid_q[cur] && dirty_q[cur])
              rsp_q <= mk_wb(cur, 1'b1, ofile_q[cur], opage_q[cur]);
            else
              rsp_q <= mk(ST_OK, cur, 1'b0, 1'b1);
            valid_q[cur] <= 1'b1;
            pin_q[cur]   <= PinW'(1);
            ref_q[cur]   <= 1'b1;
            dirty_q[cur] <= 1'b0;
            ofile_q[cur] <= req_q.file_id;
            opage_q[cur] <= req_q.page_no;
            rsp_vld_q    <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            ref_q[cur] <= 1'b0;
            if (cnt_q == CntW'(2 * NUM_FRAMES - 1)) begin
              rsp_q     <= mk(ST_EXCEEDED, '0, 1'b0, 1'b1);
              rsp_vld_q <= 1'b1;
              state_q   <= S_IDLE;
            end
          end
        end
        // flush scan from frame 0 upward
        S_FLUSH: begin
          if (!rsp_vld_q) begin
            if (match && pin_q[cur] != '0) begin
              rsp_q       <= mk(ST_PINNED, cur, 1'b0, 1'b1);
              rsp_vld_q   <= 1'b1;
              state_q     <= S_IDLE;
            end else begin
              if (match) begin
                valid_q[cur] <= 1'b0;
                ref_q[cur]   <= 1'b0;
                dirty_q[cur] <= 1'b0;
                pin_q[cur]   <= '0;
              end
              if (match && dirty_q[cur]) begin
                rsp_q     <= mk_wb(cur, 1'b0, ofile_q[cur], opage_q[cur]);
                rsp_vld_q <= 1'b1;
                state_q   <= S_OUT;
              end else if (idx_last) begin
                rsp_q     <= mk(ST_OK, '0, 1'b0, 1'b1);
                rsp_vld_q <= 1'b1;
                state_q   <= S_IDLE;
              end
              idx_q <= idx_q + 1'b1;
              if (idx_last) cnt_q <= CntW'(1);
            end
          end
        end
        // hold a flush write-back until taken
        S_OUT: begin
          if (rsp_o.ready) begin
            if (cnt_q == CntW'(1)) begin
              rsp_q     <= mk(ST_OK, '0, 1'b0, 1'b1);
              rsp_vld_q <= 1'b1;
              state_q   <= S_IDLE;
            end else begin
              rsp_vld_q <= 1'b0;
              state_q   <= S_FLUSH;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result channel never changes a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.data))
    else $error("held result changed");
  // requests only taken while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> state_q == S_IDLE && !rsp_vld_q)
    else $error("ready outside idle");
  // sweep count stays within two revolutions
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> cnt_q < CntW'(2 * NUM_FRAMES))
    else $error("sweep overran");

endmodule
`default_nettype wire
